### hw/rtl/vsc_pkg.sv
// Shared types and constants for the vending sale controller.
// Status codes, register indexes and price reset values; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vsc_pkg;

  typedef enum logic [2:0] {
    ST_AWAIT     = 3'd0,
    ST_DISPENSED = 3'd1,
    ST_SHORT     = 3'd2,
    ST_SOLD_OUT  = 3'd3,
    ST_INVALID   = 3'd4,
    ST_EXIT      = 3'd5,
    ST_BUSY      = 3'd6,
    ST_NO_SALE   = 3'd7
  } status_t;

  // Price register indexes on the configuration port.
  localparam logic [2:0] REG_PRICE_WATER      = 3'd0;
  localparam logic [2:0] REG_PRICE_ORANGE     = 3'd1;
  localparam logic [2:0] REG_PRICE_APPLE      = 3'd2;
  localparam logic [2:0] REG_PRICE_LEMON_SODA = 3'd3;
  localparam logic [2:0] REG_PRICE_COLA       = 3'd4;
  localparam int         NUM_PRICES           = 5;

  localparam logic [2:0] PRODUCT_EXIT = 3'd6;

  localparam logic [7:0] PRICE_RESET [NUM_PRICES] = '{8'd9, 8'd8, 8'd8, 8'd4, 8'd4};

  localparam int MONEY_W  = 13;
  localparam int CHANGE_W = 16;
  localparam int TENS_W   = 13;

  // Reciprocal of ten: x * 52429 >> 19 is exact for every 16-bit x.
  localparam logic [15:0] RECIP_TEN  = 16'd52429;
  localparam int          RECIP_SHIFT = 19;

endpackage

`default_nettype wire

### hw/rtl/vending_sale_controller.sv
// Vending sale controller top level: select/pay stream in, one status result out.
// Depends on vsc_pkg for status codes, register indexes and constants.
`timescale 1ns / 1ps
`default_nettype none

// One result comes out for every input transfer, in order. An item passes
// three registers: the input register (coin value summed there), the sale
// register (stock, due and paid total updated there), and the output register
// (change split into 10, 5, 2 and 1 coins there). A new item is taken every
// cycle while the output side keeps up; the sale state update between the first
// two registers sets that one-item-per-cycle figure. The user must write prices
// on the cfg port (index 0 water up to 4 cola) only while idle; no check enforces it.
module vending_sale_controller #(
  parameter int NUM_PRODUCTS  = 5,
  parameter int INITIAL_STOCK = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: product[2:0], coins_one[10:3], coins_two[18:11], coins_five[26:19],
  //        coins_ten[34:27], zero pad[39:35]
  input  wire logic [39:0] s_axis_tdata,
  // tuser: cmd[0]
  input  wire logic        s_axis_tuser,
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: dispensed[2:0], amount_due[10:3], change_total[26:11], change_tens[39:27],
  //        change_fives[40], change_twos[42:41], change_ones[43], zero pad[47:44]
  output logic [47:0]      m_axis_tdata,
  // tuser: status[2:0]
  output logic [2:0]       m_axis_tuser,
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  // ---------------- configuration ----------------
  logic [7:0] price [vsc_pkg::NUM_PRICES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vsc_pkg::NUM_PRICES; i++) begin
        price[i] <= vsc_pkg::PRICE_RESET[i];
      end
    end else if (cfg_valid && (cfg_index < 3'(vsc_pkg::NUM_PRICES))) begin
      price[cfg_index] <= cfg_data;
    end
  end

  // ---------------- handshake chain ----------------
  logic a_valid, b_valid;
  logic out_ready, b_ready, a_ready;
  logic adv_a, adv_b, adv_out;

  assign out_ready     = !m_axis_tvalid || m_axis_tready;
  assign b_ready       = !b_valid || out_ready;
  assign a_ready       = !a_valid || b_ready;
  assign s_axis_tready = a_ready;
  assign adv_a         = s_axis_tvalid && a_ready;
  assign adv_b         = a_valid && b_ready;
  assign adv_out       = b_valid && out_ready;

  // ---------------- input register ----------------
  logic                        a_cmd;
  logic [2:0]                  a_prod;
  logic [vsc_pkg::MONEY_W-1:0] a_money;
  logic [vsc_pkg::MONEY_W-1:0] money_in;

  assign money_in = vsc_pkg::MONEY_W'(s_axis_tdata[10:3])
                  + vsc_pkg::MONEY_W'(s_axis_tdata[18:11]) * vsc_pkg::MONEY_W'(2)
                  + vsc_pkg::MONEY_W'(s_axis_tdata[26:19]) * vsc_pkg::MONEY_W'(5)
                  + vsc_pkg::MONEY_W'(s_axis_tdata[34:27]) * vsc_pkg::MONEY_W'(10);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv_a) begin
      a_valid <= 1'b1;
    end else if (adv_b) begin
      a_valid <= 1'b0;
    end
    if (adv_a) begin
      a_cmd   <= s_axis_tuser;
      a_prod  <= s_axis_tdata[2:0];
      a_money <= money_in;
    end
  end

  // ---------------- sale state ----------------
  logic [7:0]  stock [NUM_PRODUCTS];
  logic [7:0]  remaining_due;
  logic [15:0] paid_total;
  logic [7:0]  sale_price;
  logic [2:0]  selected_product;
  logic        sale_open;

  logic [7:0]  remaining_due_next;
  logic [15:0] paid_total_next;
  logic [7:0]  sale_price_next;
  logic [2:0]  selected_product_next;
  logic        sale_open_next;

  logic [NUM_PRODUCTS-1:0] hit;
  logic [7:0]              stock_sel, price_sel;
  logic                    take_stock;
  logic [16:0]             sum_wide;
  logic [15:0]             sum_sat;

  vsc_pkg::status_t           b_status, b_status_next;
  logic [2:0]                 b_disp, b_disp_next;
  logic [7:0]                 b_due, b_due_next;
  logic [vsc_pkg::CHANGE_W-1:0] b_change, b_change_next;

  always_comb begin
    stock_sel = '0;
    price_sel = '0;
    for (int i = 0; i < NUM_PRODUCTS; i++) begin
      hit[i] = (a_prod == 3'(i + 1));
      if (hit[i]) begin
        stock_sel = stock[i];
        price_sel = price[i];
      end
    end
  end

  assign sum_wide = {1'b0, paid_total} + 17'(a_money);
  assign sum_sat  = sum_wide[16] ? 16'hFFFF : sum_wide[15:0];

  always_comb begin
    b_status_next         = vsc_pkg::ST_INVALID;
    b_disp_next           = '0;
    b_due_next            = '0;
    b_change_next         = '0;
    take_stock            = 1'b0;
    remaining_due_next    = remaining_due;
    paid_total_next       = paid_total;
    sale_price_next       = sale_price;
    selected_product_next = selected_product;
    sale_open_next        = sale_open;
    if (!a_cmd) begin
      if (sale_open) begin
        b_status_next = vsc_pkg::ST_BUSY;
        b_due_next    = remaining_due;
      end else if (a_prod == vsc_pkg::PRODUCT_EXIT) begin
        b_status_next = vsc_pkg::ST_EXIT;
      end else if (hit == '0) begin
        b_status_next = vsc_pkg::ST_INVALID;
      end else if (stock_sel == 8'd0) begin
        b_status_next = vsc_pkg::ST_SOLD_OUT;
      end else begin
        take_stock = 1'b1;
        if (price_sel == 8'd0) begin
          // A free product leaves at once and no sale stays open.
          b_status_next = vsc_pkg::ST_DISPENSED;
          b_disp_next   = a_prod;
        end else begin
          b_status_next         = vsc_pkg::ST_AWAIT;
          b_due_next            = price_sel;
          sale_open_next        = 1'b1;
          selected_product_next = a_prod;
          sale_price_next       = price_sel;
          remaining_due_next    = price_sel;
          paid_total_next       = '0;
        end
      end
    end else begin
      if (!sale_open) begin
        b_status_next = vsc_pkg::ST_NO_SALE;
      end else if (sum_sat < 16'(sale_price)) begin
        b_status_next      = vsc_pkg::ST_SHORT;
        remaining_due_next = 8'(16'(sale_price) - sum_sat);
        b_due_next         = remaining_due_next;
        paid_total_next    = sum_sat;
      end else begin
        b_status_next         = vsc_pkg::ST_DISPENSED;
        b_disp_next           = selected_product;
        b_change_next         = sum_sat - 16'(sale_price);
        sale_open_next        = 1'b0;
        remaining_due_next    = '0;
        paid_total_next       = '0;
        sale_price_next       = '0;
        selected_product_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PRODUCTS; i++) begin
        stock[i] <= 8'(INITIAL_STOCK);
      end
      remaining_due    <= '0;
      paid_total       <= '0;
      sale_price       <= '0;
      selected_product <= '0;
      sale_open        <= 1'b0;
      b_valid          <= 1'b0;
    end else begin
      if (adv_b) begin
        for (int i = 0; i < NUM_PRODUCTS; i++) begin
          if (take_stock && hit[i]) begin
            stock[i] <= stock[i] - 8'd1;
          end
        end
        remaining_due    <= remaining_due_next;
        paid_total       <= paid_total_next;
        sale_price       <= sale_price_next;
        selected_product <= selected_product_next;
        sale_open        <= sale_open_next;
        b_valid          <= 1'b1;
      end else if (adv_out) begin
        b_valid <= 1'b0;
      end
    end
    if (adv_b) begin
      b_status <= b_status_next;
      b_disp   <= b_disp_next;
      b_due    <= b_due_next;
      b_change <= b_change_next;
    end
  end

  // ---------------- change split and output register ----------------
  logic [31:0]                  tens_prod;
  logic [vsc_pkg::TENS_W-1:0]   tens;
  logic [3:0]                   rest, rest_low;
  logic                         fives;

  assign tens_prod = 32'(b_change) * 32'(vsc_pkg::RECIP_TEN);
  assign tens      = vsc_pkg::TENS_W'(tens_prod >> vsc_pkg::RECIP_SHIFT);
  assign rest      = 4'(b_change - 16'(tens) * 16'd10);
  assign fives     = (rest >= 4'd5);
  assign rest_low  = fives ? rest - 4'd5 : rest;

  vsc_pkg::status_t           out_status;
  logic [2:0]                 out_disp;
  logic [7:0]                 out_due;
  logic [vsc_pkg::CHANGE_W-1:0] out_change;
  logic [vsc_pkg::TENS_W-1:0] out_tens;
  logic                       out_fives;
  logic [1:0]                 out_twos;
  logic                       out_ones;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (adv_out) begin
      out_status <= b_status;
      out_disp   <= b_disp;
      out_due    <= b_due;
      out_change <= b_change;
      out_tens   <= tens;
      out_fives  <= fives;
      out_twos   <= rest_low[2:1];
      out_ones   <= rest_low[0];
    end
  end

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {4'b0, out_ones, out_twos, out_fives, out_tens,
                         out_change, out_due, out_disp};

`ifndef SYNTHESIS
  // An open sale always still has something owed.
  assert property (@(posedge clk) disable iff (rst) sale_open |-> remaining_due != 8'd0)
    else $error("open sale with nothing due");

  assert property (@(posedge clk) disable iff (rst)
    sale_open |-> (selected_product != 3'd0) && (selected_product <= 3'(NUM_PRODUCTS)))
    else $error("open sale without a valid product");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((out_status == vsc_pkg::ST_DISPENSED) == (out_disp != 3'd0)))
    else $error("dispensed product does not match status");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_status != vsc_pkg::ST_DISPENSED) |-> out_change == '0)
    else $error("change without a dispense");

  // The coin split must add back up to the change total.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (17'(out_tens) * 17'd10 + 17'(out_fives) * 17'd5
                       + 17'(out_twos) * 17'd2 + 17'(out_ones)) == 17'(out_change))
    else $error("change coins do not sum to change total");
`endif

endmodule

`default_nettype wire
